// File: rtl/core/vrcm_pkg.sv
// Shared types and constants for the voxel ray clip and march block.
// Used by every module under rtl/core except vrcm_fifo; depends on nothing.
`timescale 1ns / 1ps
package vrcm_pkg;

  localparam int CoordW   = 24;            // input coordinate width
  localparam int FracBits = 8;             // fixed point fraction bits
  localparam int DimW     = 7;             // grid dimension register width
  localparam int DirW     = CoordW + 1;    // end - start
  localparam int PtW      = CoordW + 2;    // clipped / marched points
  localparam int IdxW     = 18;            // linear voxel index
  localparam int NumW     = 53;            // divider dividend width
  localparam int DenW     = DirW + 1;      // divider divisor width
  localparam int IncqW    = FracBits + 1;  // per-step whole increment
  localparam int RemW     = DenW + 1;      // marching remainder

  typedef enum logic [1:0] {
    REG_DIM_X = 2'd0,
    REG_DIM_Y = 2'd1,
    REG_DIM_Z = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic            start;
    logic [NumW-1:0] num;
    logic [DenW-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic            done;
    logic [NumW-1:0] quo;
    logic [DenW-1:0] rem;
  } div_rsp_t;

  // one classified segment, handed from the front to the marcher
  typedef struct packed {
    logic                       in_box;
    logic                       stepped;
    logic [2:0]                 neg;
    logic [2:0][PtW-1:0]        pt;
    logic [2:0][IncqW-1:0]      incq;
    logic [2:0][DenW-1:0]       incr;
    logic [DenW-1:0]            twoad;
  } job_t;

  typedef struct packed {
    logic [IdxW-1:0] voxel_index;
    logic            index_valid;
    logic            inside_res;
    logic            last;
  } res_t;

  // round to voxel: add one half, truncate, clamp into [0, dim-1]
  function automatic logic [DimW-1:0] to_voxel(logic signed [PtW-1:0] v,
                                               logic [DimW-1:0] dim);
    logic signed [PtW:0]  r;
    logic [PtW-FracBits-1:0] q;
    logic [DimW-1:0] res;
    r = (PtW+1)'(v) + $signed((PtW+1)'(1 << (FracBits - 1)));
    q = r[PtW-1:FracBits];
    if (r[PtW] || dim == '0) begin
      res = '0;
    end else if (q > (PtW-FracBits)'(dim - DimW'(1))) begin
      res = dim - DimW'(1);
    end else begin
      res = q[DimW-1:0];
    end
    return res;
  endfunction

endpackage

// File: rtl/core/vrcm_div.sv
// Restoring divider, one quotient bit per cycle, quotient and remainder.
// Depends on vrcm_pkg for widths and the request/response structs.
`timescale 1ns / 1ps
module vrcm_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  vrcm_pkg::div_req_t req_i,
  output vrcm_pkg::div_rsp_t rsp_o
);
  import vrcm_pkg::*;

  localparam int CntW = $clog2(NumW + 1);

  logic            busy_q, done_q;
  logic [CntW-1:0] cnt_q;
  logic [DenW:0]   rem_q;
  logic [NumW-1:0] quo_q;
  logic [DenW-1:0] den_q;
  logic [DenW:0]   trial;
  logic            ge;

  assign trial = {rem_q[DenW-1:0], quo_q[NumW-1]};
  assign ge    = trial >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(NumW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CntW'(1);
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      quo_q <= req_i.num;
      rem_q <= '0;
      den_q <= req_i.den;
    end else if (busy_q) begin
      rem_q <= ge ? trial - {1'b0, den_q} : trial;
      quo_q <= {quo_q[NumW-2:0], ge};
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quo  = quo_q;
  assign rsp_o.rem  = rem_q[DenW-1:0];

endmodule

// File: rtl/core/vrcm_fifo.sv
// Small first-in first-out queue with occupancy count.
// Generic; used for the job queue and the result queue.
`timescale 1ns / 1ps
module vrcm_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     push_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic                     full_o,
  input  logic                     pop_i,
  output logic [WIDTH-1:0]         rdata_o,
  output logic                     empty_o,
  output logic [$clog2(DEPTH):0]   count_o
);
  localparam int AW = $clog2(DEPTH);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW-1:0]    wr_q, rd_q;
  logic [AW:0]      cnt_q;
  logic             do_push, do_pop;

  assign full_o  = cnt_q == (AW+1)'(DEPTH);
  assign empty_o = cnt_q == '0;
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_q];
  assign count_o = cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= wr_q + AW'(1);
      if (do_pop)  rd_q <= rd_q + AW'(1);
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + (AW+1)'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - (AW+1)'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= wdata_i;
  end

endmodule

// File: rtl/core/vrcm_front.sv
// Front end: accepts a segment, clips it plane by plane, picks the major
// axis and sets up per-step increments. Depends on vrcm_pkg; talks to vrcm_div via ports.
`timescale 1ns / 1ps
module vrcm_front #(
  parameter int MAX_DIM = 64
) (
  input  logic                                         clk_i,
  input  logic                                         rst_ni,
  input  logic                                         push_i,
  output logic                                         full_o,
  input  logic signed [vrcm_pkg::CoordW-1:0]           start_x_i,
  input  logic signed [vrcm_pkg::CoordW-1:0]           start_y_i,
  input  logic signed [vrcm_pkg::CoordW-1:0]           start_z_i,
  input  logic signed [vrcm_pkg::CoordW-1:0]           end_x_i,
  input  logic signed [vrcm_pkg::CoordW-1:0]           end_y_i,
  input  logic signed [vrcm_pkg::CoordW-1:0]           end_z_i,
  input  logic [2:0][vrcm_pkg::DimW-1:0]               dims_i,
  output vrcm_pkg::div_req_t                           div_req_o,
  input  vrcm_pkg::div_rsp_t                           div_rsp_i,
  output logic                                         job_valid_o,
  input  logic                                         job_full_i,
  output vrcm_pkg::job_t                               job_o,
  output logic [$clog2(MAX_DIM+1)-1:0]                 steps_o
);
  import vrcm_pkg::*;

  localparam int SW = $clog2(MAX_DIM + 1);
  localparam int PW = 2 * DirW + 2;   // product width

  typedef enum logic [8:0] {
    F_IDLE  = 9'b000000001,
    F_TEST  = 9'b000000010,
    F_MUL   = 9'b000000100,
    F_GO    = 9'b000001000,
    F_WAIT  = 9'b000010000,
    F_MAJOR = 9'b000100000,
    F_SGO   = 9'b001000000,
    F_SWAIT = 9'b010000000,
    F_PUSH  = 9'b100000000
  } fstate_e;

  fstate_e state_q, state_d;
  logic [2:0] pl_q, pl_d;
  logic [1:0] m_q, m_d;
  logic [1:0] ax_q;

  logic signed [CoordW-1:0] org_q [3];
  logic signed [DirW-1:0]   dir_q [3];
  logic signed [PtW-1:0]    p1_q [3];
  logic signed [PtW-1:0]    p2_q [3];
  logic signed [PtW-1:0]    cpl_q;
  logic signed [PtW:0]      cdiff_q;
  logic signed [PW-1:0]     prod_q;
  logic                     tsel_q, inside_q, stepped_q;
  logic [SW-1:0]            steps_q;
  logic [IncqW-1:0]         incq_q [3];
  logic [DenW-1:0]          incr_q [3];
  logic [DenW-1:0]          twoad_q;

  // plane test
  logic                     lo;
  logic [1:0]               ax;
  logic signed [DimW+1:0]   dm1 [3];
  logic signed [PtW-1:0]    bnd [3];
  logic signed [PtW-1:0]    cpl;
  logic signed [PtW:0]      d1, d2;
  logic                     d1n, d2n, dzero;

  // division operands
  logic [PW-1:0]            absprod;
  logic [DirW-1:0]          absda;
  logic                     qneg;
  logic signed [PtW-1:0]    qval, tval;

  // major axis
  logic [DirW-1:0]          ad [3];
  logic [1:0]               maj;
  logic signed [PtW:0]      span;
  logic [PtW:0]             aspan, shv;
  logic [SW-1:0]            steps_n;

  logic                     m_last, pl_last;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dm1[i] = $signed({2'b00, dims_i[i]}) - $signed((DimW+2)'(1));
      bnd[i] = PtW'(dm1[i]) <<< FracBits;
      ad[i]  = dir_q[i][DirW-1] ? DirW'(-dir_q[i]) : DirW'(dir_q[i]);
    end
  end

  assign lo    = pl_q < 3'd3;
  assign ax    = lo ? pl_q[1:0] : 2'(pl_q - 3'd3);
  assign cpl   = lo ? '0 : bnd[ax];
  assign d1    = lo ? (PtW+1)'(p1_q[ax]) - (PtW+1)'(cpl) : (PtW+1)'(cpl) - (PtW+1)'(p1_q[ax]);
  assign d2    = lo ? (PtW+1)'(p2_q[ax]) - (PtW+1)'(cpl) : (PtW+1)'(cpl) - (PtW+1)'(p2_q[ax]);
  assign d1n   = d1[PtW];
  assign d2n   = d2[PtW];
  assign dzero = dir_q[ax] == '0;

  assign absprod = prod_q[PW-1] ? PW'(-prod_q) : PW'(prod_q);
  assign absda   = ad[ax_q];
  assign qneg    = prod_q[PW-1] ^ dir_q[ax_q][DirW-1];
  assign qval    = $signed(div_rsp_i.quo[PtW-1:0]);
  assign tval    = qneg ? PtW'(org_q[m_q]) - qval : PtW'(org_q[m_q]) + qval;

  always_comb begin
    if (ad[0] >= ad[1] && ad[0] >= ad[2]) begin
      maj = 2'd0;
    end else if (ad[1] >= ad[2]) begin
      maj = 2'd1;
    end else begin
      maj = 2'd2;
    end
    span  = (PtW+1)'(p2_q[maj]) - (PtW+1)'(p1_q[maj]);
    aspan = span[PtW] ? (PtW+1)'(-span) : (PtW+1)'(span);
    shv   = aspan >> FracBits;
    if (ad[maj] == '0) begin
      steps_n = '0;
    end else if (shv > (PtW+1)'(MAX_DIM)) begin
      steps_n = SW'(MAX_DIM);
    end else begin
      steps_n = shv[SW-1:0];
    end
  end

  assign m_last  = m_q == 2'd2;
  assign pl_last = pl_q == 3'd5;

  // divider requests
  always_comb begin
    div_req_o = '0;
    case (state_q)
      F_GO: begin
        div_req_o.start = 1'b1;
        div_req_o.num   = NumW'({absprod[PW-3:0], 1'b0}) + NumW'(absda);
        div_req_o.den   = {absda, 1'b0};
      end
      F_SGO: begin
        div_req_o.start = 1'b1;
        div_req_o.num   = NumW'({ad[m_q], (FracBits+1)'(0)});
        div_req_o.den   = twoad_q;
      end
      default: ;
    endcase
  end

  always_comb begin
    state_d = state_q;
    pl_d    = pl_q;
    m_d     = m_q;
    case (state_q)
      F_IDLE: begin
        if (push_i) begin
          state_d = F_TEST;
          pl_d    = '0;
        end
      end
      F_TEST: begin
        if (d1n && d2n) begin
          state_d = F_PUSH;
        end else if ((!d1n && !d2n) || dzero) begin
          if (pl_last) state_d = F_MAJOR;
          else pl_d = pl_q + 3'd1;
        end else begin
          state_d = F_MUL;
          m_d     = '0;
        end
      end
      F_MUL, F_WAIT: begin
        if ((state_q == F_MUL && m_q == ax_q) || (state_q == F_WAIT && div_rsp_i.done)) begin
          if (m_last) begin
            if (pl_last) begin
              state_d = F_MAJOR;
            end else begin
              state_d = F_TEST;
              pl_d    = pl_q + 3'd1;
            end
          end else begin
            state_d = F_MUL;
            m_d     = m_q + 2'd1;
          end
        end else if (state_q == F_MUL) begin
          state_d = F_GO;
        end
      end
      F_GO:  state_d = F_WAIT;
      F_MAJOR: begin
        m_d     = '0;
        state_d = (steps_n == '0) ? F_PUSH : F_SGO;
      end
      F_SGO: state_d = F_SWAIT;
      F_SWAIT: begin
        if (div_rsp_i.done) begin
          if (m_last) begin
            state_d = F_PUSH;
          end else begin
            state_d = F_SGO;
            m_d     = m_q + 2'd1;
          end
        end
      end
      F_PUSH: if (!job_full_i) state_d = F_IDLE;
      default: state_d = F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      pl_q    <= '0;
      m_q     <= '0;
    end else begin
      state_q <= state_d;
      pl_q    <= pl_d;
      m_q     <= m_d;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      F_IDLE: begin
        org_q[0] <= start_x_i;
        org_q[1] <= start_y_i;
        org_q[2] <= start_z_i;
        dir_q[0] <= DirW'(end_x_i) - DirW'(start_x_i);
        dir_q[1] <= DirW'(end_y_i) - DirW'(start_y_i);
        dir_q[2] <= DirW'(end_z_i) - DirW'(start_z_i);
        p1_q[0]  <= PtW'(start_x_i);
        p1_q[1]  <= PtW'(start_y_i);
        p1_q[2]  <= PtW'(start_z_i);
        p2_q[0]  <= PtW'(end_x_i);
        p2_q[1]  <= PtW'(end_y_i);
        p2_q[2]  <= PtW'(end_z_i);
      end
      F_TEST: begin
        inside_q  <= !(d1n && d2n);
        stepped_q <= 1'b0;
        tsel_q    <= !d1n;
        cpl_q     <= cpl;
        ax_q      <= ax;
        cdiff_q   <= (PtW+1)'(cpl) - (PtW+1)'(org_q[ax]);
      end
      F_MUL: begin
        if (m_q == ax_q) begin
          if (tsel_q) p2_q[m_q] <= cpl_q;
          else p1_q[m_q] <= cpl_q;
        end
        prod_q <= dir_q[m_q] * cdiff_q;
      end
      F_WAIT: begin
        if (div_rsp_i.done) begin
          if (tsel_q) p2_q[m_q] <= tval;
          else p1_q[m_q] <= tval;
        end
      end
      F_MAJOR: begin
        steps_q   <= steps_n;
        stepped_q <= steps_n != '0;
        twoad_q   <= {ad[maj], 1'b0};
      end
      F_SWAIT: begin
        if (div_rsp_i.done) begin
          incq_q[m_q] <= div_rsp_i.quo[IncqW-1:0];
          incr_q[m_q] <= div_rsp_i.rem;
        end
      end
      default: ;
    endcase
  end

  assign full_o      = state_q != F_IDLE;
  assign job_valid_o = state_q == F_PUSH;
  assign steps_o     = steps_q;

  always_comb begin
    job_o.in_box  = inside_q;
    job_o.stepped = stepped_q;
    job_o.twoad   = twoad_q;
    for (int i = 0; i < 3; i++) begin
      job_o.neg[i]  = dir_q[i][DirW-1];
      job_o.pt[i]   = p1_q[i];
      job_o.incq[i] = incq_q[i];
      job_o.incr[i] = incr_q[i];
    end
  end

endmodule

// File: rtl/core/vrcm_back.sv
// Back end: marches a classified segment one voxel per cycle while the result
// queue has room, and forms the linear index in a short pipeline. Depends on vrcm_pkg.
`timescale 1ns / 1ps
module vrcm_back #(
  parameter int MAX_DIM   = 64,
  parameter int OUT_DEPTH = 8
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 job_valid_i,
  input  vrcm_pkg::job_t                       job_i,
  input  logic [$clog2(MAX_DIM+1)-1:0]         steps_i,
  output logic                                 job_pop_o,
  input  logic [2:0][vrcm_pkg::DimW-1:0]       dims_i,
  input  logic [$clog2(OUT_DEPTH):0]           out_cnt_i,
  output logic                                 res_push_o,
  output vrcm_pkg::res_t                       res_o
);
  import vrcm_pkg::*;

  localparam int SW  = $clog2(MAX_DIM + 1);
  localparam int OCW = $clog2(OUT_DEPTH) + 1;

  logic                  active_q;
  logic signed [PtW-1:0] pt_q [3];
  logic [RemW-1:0]       ra_q [3];
  logic [RemW-1:0]       ra_n [3];
  logic [SW-1:0]         k_q;

  logic                  credit, issue, last;
  logic [IncqW:0]        delta [3];
  logic signed [PtW-1:0] ptn [3];

  logic                  s1v_q, s2v_q, s3v_q;
  logic signed [PtW-1:0] s1_pt_q [3];
  logic [2:0]            s1_f_q, s2_f_q, s3_f_q;   // {stepped, inside, last}
  logic [DimW-1:0]       s2_c_q [3];
  logic [DimW-1:0]       s3_c0_q;
  logic [2*DimW-1:0]     s3_m1_q, dxy_q;
  logic [3*DimW-1:0]     s3_m2_q;
  logic [3*DimW+1:0]     sum;

  assign credit = ((OCW+1)'(out_cnt_i) + (OCW+1)'(s1v_q) + (OCW+1)'(s2v_q)
                   + (OCW+1)'(s3v_q)) < (OCW+1)'(OUT_DEPTH);
  assign issue  = active_q && credit;
  assign last   = !job_i.stepped || ((SW+1)'(k_q) + (SW+1)'(1) == (SW+1)'(steps_i));
  assign job_pop_o = issue && last;

  // advance the fractional remainder per axis; a wrap carries one more unit
  always_comb begin
    logic [RemW-1:0] t;
    logic            c;
    for (int i = 0; i < 3; i++) begin
      t = ra_q[i] + RemW'(job_i.incr[i]);
      c = t >= RemW'(job_i.twoad);
      ra_n[i] = c ? t - RemW'(job_i.twoad) : t;
      delta[i] = (IncqW+1)'(job_i.incq[i]) + (IncqW+1)'(c);
      ptn[i] = job_i.neg[i] ? pt_q[i] - PtW'(delta[i]) : pt_q[i] + PtW'(delta[i]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      s1v_q    <= 1'b0;
      s2v_q    <= 1'b0;
      s3v_q    <= 1'b0;
    end else begin
      if (!active_q && job_valid_i) active_q <= 1'b1;
      else if (job_pop_o) active_q <= 1'b0;
      s1v_q <= issue;
      s2v_q <= s1v_q;
      s3v_q <= s2v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    dxy_q <= dims_i[0] * dims_i[1];
    if (!active_q) begin
      k_q <= '0;
      for (int i = 0; i < 3; i++) begin
        pt_q[i] <= $signed(job_i.pt[i]);
        ra_q[i] <= RemW'(job_i.twoad >> 1);
      end
    end else if (issue) begin
      k_q <= k_q + SW'(1);
      for (int i = 0; i < 3; i++) begin
        pt_q[i] <= ptn[i];
        ra_q[i] <= ra_n[i];
      end
    end
    for (int i = 0; i < 3; i++) begin
      s1_pt_q[i] <= ptn[i];
      s2_c_q[i]  <= s1_f_q[2] ? to_voxel(s1_pt_q[i], dims_i[i]) : '0;
    end
    s1_f_q  <= {job_i.stepped, job_i.in_box, last};
    s2_f_q  <= s1_f_q;
    s3_f_q  <= s2_f_q;
    s3_c0_q <= s2_c_q[0];
    s3_m1_q <= s2_c_q[1] * dims_i[0];
    s3_m2_q <= s2_c_q[2] * dxy_q;
  end

  assign sum = (3*DimW+2)'(s3_c0_q) + (3*DimW+2)'(s3_m1_q) + (3*DimW+2)'(s3_m2_q);

  assign res_push_o        = s3v_q;
  assign res_o.voxel_index = IdxW'(sum);
  assign res_o.index_valid = s3_f_q[2];
  assign res_o.inside_res  = s3_f_q[1];
  assign res_o.last        = s3_f_q[0];

endmodule

// File: rtl/core/voxel_ray_clip_and_march_top.sv
// Top level of the voxel ray clip and march block: configuration registers,
// front end, job queue, marcher and result queue. Depends on vrcm_pkg and all of rtl/core.
//
// Usage: a segment (start and end, signed Q15.8 grid coordinates) is written
// by raising push while full is low. Results come out of a queue: while
// empty is low the oldest result is on the result ports, and pop takes
// it. A segment gives one result per stepped voxel, or a single result with
// index_valid_o low on a miss or an empty run; last_o marks its final one.
// Grid sizes are written on the cfg port while the block is idle.
// Flow: the front runs plane tests and handoff, two divisions for each of up
// to six planes that cut the segment, and three step-setup divisions for a
// stepped run, all on one shared bit-serial divider. The marcher then emits
// one voxel per cycle while the result queue has room, up to MAX_DIM per
// segment with a pause between segments; each step passes registered stages
// s1, s2 and s3 to the result queue. The front takes a new segment as soon
// as its job is queued, so clipping of the next overlaps marching of this one.
// Reset empties both queues and sets every grid size to 1. When the receiver
// stalls, the result queue fills, the marcher holds, then the job queue and
// finally full rises; nothing is dropped.
`timescale 1ns / 1ps
module voxel_ray_clip_and_march_top #(
  parameter int MAX_DIM = 64
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               push,
  output logic                               full,
  input  logic signed [vrcm_pkg::CoordW-1:0] start_x_i,
  input  logic signed [vrcm_pkg::CoordW-1:0] start_y_i,
  input  logic signed [vrcm_pkg::CoordW-1:0] start_z_i,
  input  logic signed [vrcm_pkg::CoordW-1:0] end_x_i,
  input  logic signed [vrcm_pkg::CoordW-1:0] end_y_i,
  input  logic signed [vrcm_pkg::CoordW-1:0] end_z_i,
  output logic                               empty,
  input  logic                               pop,
  output logic [vrcm_pkg::IdxW-1:0]          voxel_index_o,
  output logic                               index_valid_o,
  output logic                               inside_res_o,
  output logic                               last_o,
  input  logic                               cfg_we_i,
  input  logic [1:0]                         cfg_idx_i,
  input  logic [vrcm_pkg::DimW-1:0]          cfg_wdata_i
);
  import vrcm_pkg::*;

  localparam int SW        = $clog2(MAX_DIM + 1);
  localparam int OutDepth  = 8;
  localparam int JobW      = $bits(job_t) + SW;

  logic [2:0][DimW-1:0] dims_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dims_q <= {3{DimW'(1)}};
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_DIM_X: dims_q[0] <= cfg_wdata_i;
        REG_DIM_Y: dims_q[1] <= cfg_wdata_i;
        REG_DIM_Z: dims_q[2] <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  div_req_t div_req;
  div_rsp_t div_rsp;
  job_t     fr_job, bk_job;
  logic [SW-1:0] fr_steps, bk_steps;
  logic     fr_valid, jq_full, jq_empty, bk_pop;
  logic     res_push;
  res_t     bk_res, out_res;
  logic [$clog2(OutDepth):0] out_cnt;

  vrcm_front #(.MAX_DIM(MAX_DIM)) u_front (
    .clk_i, .rst_ni,
    .push_i      (push),
    .full_o      (full),
    .start_x_i, .start_y_i, .start_z_i,
    .end_x_i, .end_y_i, .end_z_i,
    .dims_i      (dims_q),
    .div_req_o   (div_req),
    .div_rsp_i   (div_rsp),
    .job_valid_o (fr_valid),
    .job_full_i  (jq_full),
    .job_o       (fr_job),
    .steps_o     (fr_steps)
  );

  vrcm_div u_div (
    .clk_i, .rst_ni,
    .req_i (div_req),
    .rsp_o (div_rsp)
  );

  vrcm_fifo #(.WIDTH(JobW), .DEPTH(2)) u_jobq (
    .clk_i, .rst_ni,
    .push_i  (fr_valid),
    .wdata_i ({fr_steps, fr_job}),
    .full_o  (jq_full),
    .pop_i   (bk_pop),
    .rdata_o ({bk_steps, bk_job}),
    .empty_o (jq_empty),
    .count_o ()
  );

  vrcm_back #(.MAX_DIM(MAX_DIM), .OUT_DEPTH(OutDepth)) u_back (
    .clk_i, .rst_ni,
    .job_valid_i (!jq_empty),
    .job_i       (bk_job),
    .steps_i     (bk_steps),
    .job_pop_o   (bk_pop),
    .dims_i      (dims_q),
    .out_cnt_i   (out_cnt),
    .res_push_o  (res_push),
    .res_o       (bk_res)
  );

  vrcm_fifo #(.WIDTH($bits(res_t)), .DEPTH(OutDepth)) u_outq (
    .clk_i, .rst_ni,
    .push_i  (res_push),
    .wdata_i (bk_res),
    .full_o  (),
    .pop_i   (pop),
    .rdata_o (out_res),
    .empty_o (empty),
    .count_o (out_cnt)
  );

  assign voxel_index_o = out_res.voxel_index;
  assign index_valid_o = out_res.index_valid;
  assign inside_res_o  = out_res.inside_res;
  assign last_o        = out_res.last;

  a_valid_inside: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && index_valid_o) |-> inside_res_o)
    else $error("stepped voxel reported outside the box");

  a_single_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !index_valid_o) |-> last_o)
    else $error("miss or empty run not marked last");

  a_out_credit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push |-> (out_cnt < ($clog2(OutDepth)+1)'(OutDepth)))
    else $error("marcher wrote into a full result queue");

  a_job_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fr_valid && jq_full) |=> fr_valid)
    else $error("job dropped while queue full");

endmodule

// File: sim/tb_voxel_ray_clip_and_march_top.sv
// Testbench for voxel_ray_clip_and_march_top: random and directed segments
// checked against an in-bench clip-and-march predictor. Depends on vrcm_pkg.
`timescale 1ns / 1ps

class voxel_scoreboard;
  vrcm_pkg::res_t pending[$];
  longint dims[3];
  int errs;

  function new();
    dims = '{1, 1, 1};
    errs = 0;
  endfunction

  // nearest, ties away from zero
  function longint div_near(longint n, longint d);
    longint an, ad, q;
    an = n < 0 ? -n : n;
    ad = d < 0 ? -d : d;
    q = (2 * an + ad) / (2 * ad);
    return ((n < 0) != (d < 0)) ? -q : q;
  endfunction

  function longint snap_voxel(longint v, longint dim);
    longint r, q;
    r = v + 128;
    if (r < 0 || dim == 0) return 0;
    q = r >>> 8;
    if (q > dim - 1) q = dim - 1;
    return q;
  endfunction

  function void note_segment(logic signed [23:0] s[3], logic signed [23:0] e[3]);
    longint org[3], dir[3], p1[3], p2[3], bnd[3], ad[3];
    longint c, d1, d2, span, steps, p, idx;
    longint vx[3];
    int ax, maj;
    bit ok;
    vrcm_pkg::res_t r;
    ok = 1;
    for (int i = 0; i < 3; i++) begin
      org[i] = s[i];
      dir[i] = longint'(e[i]) - org[i];
      p1[i] = org[i];
      p2[i] = longint'(e[i]);
      bnd[i] = (dims[i] - 1) * 256;
    end
    // zero planes first, then bound planes
    for (int pl = 0; pl < 6 && ok; pl++) begin
      ax = pl % 3;
      c = pl < 3 ? 0 : bnd[ax];
      d1 = pl < 3 ? p1[ax] - c : c - p1[ax];
      d2 = pl < 3 ? p2[ax] - c : c - p2[ax];
      if (d1 < 0 && d2 < 0) begin
        ok = 0;
      end else if (!(d1 >= 0 && d2 >= 0) && dir[ax] != 0) begin
        for (int m = 0; m < 3; m++) begin
          p = org[m] + div_near(dir[m] * (c - org[ax]), dir[ax]);
          if (d1 >= 0) p2[m] = p;
          else p1[m] = p;
        end
      end
    end
    r = '0;
    r.last = 1'b1;
    if (!ok) begin
      pending.push_back(r);
      return;
    end
    for (int i = 0; i < 3; i++) ad[i] = dir[i] < 0 ? -dir[i] : dir[i];
    if (ad[0] >= ad[1] && ad[0] >= ad[2]) maj = 0;
    else if (ad[1] >= ad[2]) maj = 1;
    else maj = 2;
    span = p2[maj] - p1[maj];
    if (span < 0) span = -span;
    steps = span >>> 8;
    if (steps > 64) steps = 64;
    if (ad[maj] == 0) steps = 0;
    r.inside_res = 1'b1;
    if (steps == 0) begin
      pending.push_back(r);
      return;
    end
    for (longint k = 1; k <= steps; k++) begin
      for (int i = 0; i < 3; i++)
        vx[i] = snap_voxel(p1[i] + div_near(k * dir[i] * 256, ad[maj]), dims[i]);
      idx = vx[0] + vx[1] * dims[0] + vx[2] * dims[0] * dims[1];
      r.voxel_index = idx[17:0];
      r.index_valid = 1'b1;
      r.last = (k == steps);
      pending.push_back(r);
    end
  endfunction

  function void check_result(vrcm_pkg::res_t got);
    vrcm_pkg::res_t want;
    if (pending.size() == 0) begin
      errs++;
      if (errs <= 10) $display("unexpected result %p", got);
      return;
    end
    want = pending.pop_front();
    if (got.voxel_index !== want.voxel_index || got.index_valid !== want.index_valid ||
        got.inside_res !== want.inside_res || got.last !== want.last) begin
      errs++;
      if (errs <= 10) $display("mismatch: expected %p, got %p", want, got);
    end
  endfunction
endclass

module tb_voxel_ray_clip_and_march_top;
  import vrcm_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic push = 1'b0;
  logic pop = 1'b0;
  logic full, empty;
  logic signed [CoordW-1:0] sx = '0, sy = '0, sz = '0, ex = '0, ey = '0, ez = '0;
  logic [IdxW-1:0] voxel_index;
  logic index_valid, inside_res, last;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_idx = '0;
  logic [DimW-1:0] cfg_wdata = '0;

  voxel_scoreboard sb = new();
  bit calm = 0;
  int stall_left = 0;

  voxel_ray_clip_and_march_top DUT (
    .clk_i(clk_i), .rst_ni(rst_ni), .push(push), .full(full),
    .start_x_i(sx), .start_y_i(sy), .start_z_i(sz),
    .end_x_i(ex), .end_y_i(ey), .end_z_i(ez),
    .empty(empty), .pop(pop),
    .voxel_index_o(voxel_index), .index_valid_o(index_valid),
    .inside_res_o(inside_res), .last_o(last),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_wdata_i(cfg_wdata)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (pop && !empty) sb.check_result('{voxel_index, index_valid, inside_res, last});
  end

  // receiver: random stall bursts
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      pop = 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      pop = 1'b0;
    end else if (!calm && $urandom_range(0, 9) == 0) begin
      stall_left = $urandom_range(0, 12);
      pop = 1'b0;
    end else begin
      pop = 1'b1;
    end
  end

  task automatic send_segment(int ax, int ay, int az, int bx, int by, int bz);
    logic signed [23:0] s[3], e[3];
    @(negedge clk_i);
    sx = CoordW'(ax); sy = CoordW'(ay); sz = CoordW'(az);
    ex = CoordW'(bx); ey = CoordW'(by); ez = CoordW'(bz);
    push = 1'b1;
    s = '{sx, sy, sz};
    e = '{ex, ey, ez};
    do @(posedge clk_i); while (full);
    sb.note_segment(s, e);
    // sender gap, sometimes
    if (!calm && $urandom_range(0, 5) == 0) begin
      @(negedge clk_i);
      push = 1'b0;
      repeat ($urandom_range(0, 12)) @(negedge clk_i);
    end
  endtask

  task automatic drain();
    @(negedge clk_i);
    push = 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (1200) @(posedge clk_i);
  endtask

  task automatic set_dims(int dx, int dy, int dz);
    int v[3];
    v = '{dx, dy, dz};
    for (int i = 0; i < 3; i++) begin
      @(negedge clk_i);
      cfg_we = 1'b1;
      cfg_idx = cfg_reg_e'(i);
      cfg_wdata = DimW'(v[i]);
      @(posedge clk_i);
      sb.dims[i] = v[i] & 8'h7f;
    end
    @(negedge clk_i);
    cfg_we = 1'b0;
  endtask

  // coordinate near the box, or anywhere at all
  function automatic int pick_coord(longint dim);
    if ($urandom_range(0, 7) == 0) return int'($signed($urandom() & 24'hffffff) <<< 8) >>> 8;
    return int'($urandom_range(0, (dim + 8) * 256)) - 4 * 256;
  endfunction

  task automatic random_segments(int n);
    int a[3], b[3];
    for (int j = 0; j < n; j++) begin
      for (int i = 0; i < 3; i++) begin
        a[i] = pick_coord(sb.dims[i]);
        b[i] = pick_coord(sb.dims[i]);
      end
      if ($urandom_range(0, 9) == 0) b = a;
      send_segment(a[0], a[1], a[2], b[0], b[1], b[2]);
    end
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    // default 1x1x1 grid
    send_segment(0, 0, 0, 0, 0, 0);
    send_segment(-8388608, -8388608, -8388608, 8388607, 8388607, 8388607);
    send_segment(8388607, 0, 0, -8388608, 0, 0);
    drain();
    set_dims(64, 64, 64);
    send_segment(-2560, 100, 200, 20000, 5000, 9000);       // long run, clipped at both ends
    send_segment(16000, 16000, 16000, 0, 0, 0);             // negative direction
    send_segment(100, 100, 100, 2660, 2660, 100);           // x/y tie
    send_segment(100, 100, 100, 100, 2660, 2660);           // y/z tie
    send_segment(100, 100, 100, 100, 100, 5000);            // z major
    send_segment(-512, -512, -512, -100, -300, -256);       // miss below
    send_segment(17000, 300, 300, 20000, 900, 300);         // miss above
    send_segment(300, 300, 300, 400, 350, 320);             // empty run
    send_segment(-300, 16100, 500, 16500, -200, 16400);     // rounding spill
    send_segment(8388607, 8388607, 8388607, -8388608, -8388608, -8388608);
    drain();
    set_dims(0, 9, 2);                                      // zero dimension: misses
    send_segment(0, 0, 0, 500, 500, 200);
    random_segments(10);
    drain();
    set_dims(127, 127, 127);                                // index wrap
    send_segment(0, 0, 0, 32000, 32000, 32000);
    send_segment(32000, 32000, 32000, 16000, 31000, 32000);
    random_segments(40);
    drain();
    set_dims(7, 5, 3);
    random_segments(40);
    drain();
    set_dims(64, 12, 33);
    random_segments(40);
    drain();
    calm = 1;
    set_dims(1, 64, 2);
    random_segments(30);
    @(negedge clk_i);
    push = 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (1200) @(posedge clk_i);
    if (sb.errs == 0 && sb.pending.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #50ms;
    $display("end of test: mismatches");
    $finish;
  end
endmodule
